// ----- hdl/gasm_pkg.sv -----
// ----------------------------------------------------------------------------
// gasm_pkg
// Shared sizes, codes and the controller-to-datapath command for the
// global alignment score matrix block.
// ----------------------------------------------------------------------------
package gasm_pkg;

  // Longest sequence held; the two widths below follow from it.
  localparam int unsigned MaxLen   = 32;
  localparam int unsigned ColW     = $clog2(MaxLen + 1);
  localparam int unsigned SeqAw    = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  // Fixed port widths
  localparam int unsigned SymW     = 8;
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgGap      = 2'd0,
    CfgMatch    = 2'd1,
    CfgMismatch = 2'd2
  } cfg_idx_e;

  // Reset values of the score registers
  localparam logic signed [CfgW-1:0] GapReset      = -8'sd1;
  localparam logic signed [CfgW-1:0] MatchReset    =  8'sd1;
  localparam logic signed [CfgW-1:0] MismatchReset = -8'sd1;

  // Datapath operations for the current cycle
  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpErr    = 3'd1,
    OpBorder = 3'd2,
    OpSweep  = 3'd3,
    OpRow    = 3'd4
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   row;
    logic              last;
    logic              fin;
    logic              rd_en;
    logic [ColW-1:0]   prev_raddr;
    logic [SeqAw-1:0]  fs_raddr;
    logic              fs_we;
    logic [SeqAw-1:0]  fs_waddr;
    logic              sym_load;
  } dp_cmd_t;

endpackage

// ----- hdl/gasm_ctrl.sv -----
// ----------------------------------------------------------------------------
// gasm_ctrl
// Sequencer: takes requests, keeps sequence lengths and walks the columns.
// ----------------------------------------------------------------------------
module gasm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               action_i,
  input  logic               final_symbol_i,
  output logic               busy_o,
  output gasm_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StErr    = 5'b00010,
    StBorder = 5'b00100,
    StSweep  = 5'b01000,
    StRow    = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [gasm_pkg::ColW-1:0]   col_q, col_d;
  logic [gasm_pkg::ColW-1:0]   len_q, len_d;
  logic [gasm_pkg::ColW-1:0]   rows_q, rows_d;
  logic                        comp_q, comp_d;
  logic                        fin_q, fin_d;
  logic [gasm_pkg::ColW-1:0]   len_eff;
  logic                        last;
  logic                        fs_we;
  logic [gasm_pkg::SeqAw-1:0]  fs_waddr;
  logic                        sym_load;

  assign last   = (col_q == len_q);
  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    len_d    = len_q;
    rows_d   = rows_q;
    comp_d   = comp_q;
    fin_d    = fin_q;
    len_eff  = len_q;
    fs_we    = 1'b0;
    fs_waddr = '0;
    sym_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          fin_d    = final_symbol_i;
          sym_load = 1'b1;
          col_d    = '0;
          if (!action_i) begin
            // a load after the first sequence has closed opens a new first sequence
            if (comp_q) begin
              len_eff = '0;
              comp_d  = 1'b0;
              rows_d  = '0;
            end
            if (len_eff == gasm_pkg::ColW'(gasm_pkg::MaxLen)) begin
              state_d = StErr;
              if (final_symbol_i) begin
                comp_d = 1'b1;
                rows_d = '0;
              end
            end else begin
              fs_we    = 1'b1;
              fs_waddr = len_eff[gasm_pkg::SeqAw-1:0];
              len_d    = len_eff + gasm_pkg::ColW'(1);
              if (final_symbol_i) begin
                comp_d  = 1'b1;
                rows_d  = '0;
                state_d = StBorder;
              end
            end
          end else if (comp_q) begin
            if (rows_q == gasm_pkg::ColW'(gasm_pkg::MaxLen)) begin
              state_d = StErr;
              if (final_symbol_i) begin
                rows_d = '0;
              end
            end else begin
              rows_d  = rows_q + gasm_pkg::ColW'(1);
              state_d = StRow;
            end
          end
        end
      end
      StErr: begin
        state_d = fin_q ? StSweep : StIdle;
      end
      StBorder, StSweep, StRow: begin
        col_d = col_q + gasm_pkg::ColW'(1);
        if (last) begin
          state_d = StIdle;
          col_d   = '0;
          if (state_q == StRow && fin_q) begin
            rows_d = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      len_q   <= '0;
      rows_q  <= '0;
      comp_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      len_q   <= len_d;
      rows_q  <= rows_d;
      comp_q  <= comp_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    unique case (state_q)
      StErr:    cmd_o.op = gasm_pkg::OpErr;
      StBorder: cmd_o.op = gasm_pkg::OpBorder;
      StSweep:  cmd_o.op = gasm_pkg::OpSweep;
      StRow:    cmd_o.op = gasm_pkg::OpRow;
      default:  cmd_o.op = gasm_pkg::OpNone;
    endcase
    cmd_o.col        = col_q;
    cmd_o.row        = rows_q;
    cmd_o.last       = last;
    cmd_o.fin        = fin_q;
    // prefetch the next column; idle reads column 0 ahead of a row
    cmd_o.rd_en      = (state_q == StIdle) || ((state_q == StRow) && !last);
    cmd_o.prev_raddr = (state_q == StRow) ? (col_q + gasm_pkg::ColW'(1)) : '0;
    cmd_o.fs_raddr   = col_q[gasm_pkg::SeqAw-1:0];
    cmd_o.fs_we      = fs_we;
    cmd_o.fs_waddr   = fs_waddr;
    cmd_o.sym_load   = sym_load;
  end

endmodule

// ----- hdl/gasm_dp.sv -----
// ----------------------------------------------------------------------------
// gasm_dp
// Datapath: score registers, sequence and row memories, cell update and
// registered result.
// ----------------------------------------------------------------------------
module gasm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gasm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [gasm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic [gasm_pkg::SymW-1:0]         symbol_i,
  input  gasm_pkg::dp_cmd_t                 cmd_i,
  output logic                              result_valid_o,
  output logic signed [gasm_pkg::ScoreW-1:0] score_o,
  output logic [gasm_pkg::IdxW-1:0]         row_index_o,
  output logic [gasm_pkg::IdxW-1:0]         column_index_o,
  output logic                              row_end_o,
  output logic                              too_long_o
);

  logic signed [gasm_pkg::CfgW-1:0]   gap_q, match_q, mismatch_q;
  logic [gasm_pkg::SymW-1:0]          fs_mem [gasm_pkg::MaxLen];
  logic signed [gasm_pkg::ScoreW-1:0] prev_mem [gasm_pkg::MaxLen + 1];
  logic [gasm_pkg::SymW-1:0]          fs_rd_q, sym_q;
  logic signed [gasm_pkg::ScoreW-1:0] prev_rd_q;
  logic signed [gasm_pkg::ScoreW-1:0] diag_q, diag_d, left_q, left_d;

  logic [gasm_pkg::ColW-1:0]          mul_opnd;
  logic signed [gasm_pkg::ColW+gasm_pkg::CfgW:0] prod;
  logic signed [gasm_pkg::ScoreW-1:0] mul_s, gap_s, diag_sc;
  logic signed [gasm_pkg::ScoreW-1:0] cand_a, cand_b, cand_c, cell_max;
  logic                               prev_we;
  logic signed [gasm_pkg::ScoreW-1:0] prev_wdata;

  logic                               valid_d;
  logic signed [gasm_pkg::ScoreW-1:0] score_d;
  logic [gasm_pkg::IdxW-1:0]          row_d, col_d;
  logic                               end_d, err_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q      <= gasm_pkg::GapReset;
      match_q    <= gasm_pkg::MatchReset;
      mismatch_q <= gasm_pkg::MismatchReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gasm_pkg::CfgGap:      gap_q      <= cfg_wdata_i;
        gasm_pkg::CfgMatch:    match_q    <= cfg_wdata_i;
        gasm_pkg::CfgMismatch: mismatch_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // column 0 of a row scales the row number, elsewhere the column number
  assign mul_opnd = ((cmd_i.op == gasm_pkg::OpRow) && (cmd_i.col == '0)) ? cmd_i.row
                                                                         : cmd_i.col;
  assign prod     = $signed({1'b0, mul_opnd}) * gap_q;
  assign mul_s    = gasm_pkg::ScoreW'(prod);
  assign gap_s    = gasm_pkg::ScoreW'(gap_q);
  assign diag_sc  = (fs_rd_q == sym_q) ? gasm_pkg::ScoreW'(match_q)
                                       : gasm_pkg::ScoreW'(mismatch_q);
  assign cand_a   = diag_q + diag_sc;
  assign cand_b   = prev_rd_q + gap_s;
  assign cand_c   = left_q + gap_s;

  always_comb begin
    cell_max = cand_a;
    if (cand_b > cell_max) cell_max = cand_b;
    if (cand_c > cell_max) cell_max = cand_c;
  end

  always_comb begin
    valid_d    = 1'b0;
    score_d    = '0;
    row_d      = '0;
    col_d      = gasm_pkg::IdxW'(cmd_i.col);
    end_d      = cmd_i.last;
    err_d      = 1'b0;
    prev_we    = 1'b0;
    prev_wdata = mul_s;
    diag_d     = diag_q;
    left_d     = left_q;
    unique case (cmd_i.op)
      gasm_pkg::OpErr: begin
        valid_d = 1'b1;
        col_d   = '0;
        end_d   = 1'b0;
        err_d   = 1'b1;
      end
      gasm_pkg::OpBorder: begin
        valid_d = 1'b1;
        score_d = mul_s;
        prev_we = 1'b1;
      end
      gasm_pkg::OpSweep: begin
        prev_we = 1'b1;
      end
      gasm_pkg::OpRow: begin
        valid_d = 1'b1;
        row_d   = gasm_pkg::IdxW'(cmd_i.row);
        prev_we = 1'b1;
        diag_d  = prev_rd_q;
        if (cmd_i.col == '0) begin
          score_d    = mul_s;
          left_d     = mul_s;
          prev_wdata = cmd_i.fin ? '0 : mul_s;
        end else begin
          score_d    = cell_max;
          left_d     = cell_max;
          // on the last row restore the border as the row goes by
          prev_wdata = cmd_i.fin ? mul_s : cell_max;
        end
      end
      default: ;
    endcase
  end

  // memories: one write, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.fs_we) begin
      fs_mem[cmd_i.fs_waddr] <= symbol_i;
    end
    if (prev_we) begin
      prev_mem[cmd_i.col] <= prev_wdata;
    end
    if (cmd_i.rd_en) begin
      prev_rd_q <= prev_mem[cmd_i.prev_raddr];
      fs_rd_q   <= fs_mem[cmd_i.fs_raddr];
    end
    if (cmd_i.sym_load) begin
      sym_q <= symbol_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q         <= diag_d;
    left_q         <= left_d;
    score_o        <= score_d;
    row_index_o    <= row_d;
    column_index_o <= col_d;
    row_end_o      <= end_d;
    too_long_o     <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= valid_d;
    end
  end

endmodule

// ----- hdl/global_alignment_score_matrix.sv -----
// The first result of a request is registered from the state that the accepting edge enters.
// Throughput: a closing load or a row request walks first length plus one columns, one
//   cell a cycle with busy_o high; the next request is taken only once busy_o is low again.
// Other loads and ignored rows leave busy_o low; a dropped request gives one error result,
//   plus a silent border rewrite of first length plus one columns if it closes.
// Results cannot be stalled. Reset is asynchronous, active low; scores reset to -1/1/-1.
// ----------------------------------------------------------------------------
// global_alignment_score_matrix
// Linear-gap global alignment score matrix, one row per second-sequence
// symbol, built from a sequencer and a cell datapath.
// ----------------------------------------------------------------------------
module global_alignment_score_matrix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request port
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               action_i,
  input  logic [gasm_pkg::SymW-1:0]          symbol_i,
  input  logic                               final_symbol_i,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [gasm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gasm_pkg::CfgW-1:0]          cfg_wdata_i,
  // result port
  output logic                               result_valid_o,
  output logic signed [gasm_pkg::ScoreW-1:0] score_o,
  output logic [gasm_pkg::IdxW-1:0]          row_index_o,
  output logic [gasm_pkg::IdxW-1:0]          column_index_o,
  output logic                               row_end_o,
  output logic                               too_long_o
);

  // Commands from the sequencer to the datapath, one per cycle
  gasm_pkg::dp_cmd_t cmd;

  // Sequencer: holds the sequence lengths and the row count, decides what each
  // request does, and steps the column counter for border, sweep and row walks.
  gasm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .action_i       (action_i),
    .final_symbol_i (final_symbol_i),
    .busy_o         (busy_o),
    .cmd_o          (cmd)
  );

  // Datapath: first-sequence memory, previous-row memory with the next column
  // prefetched, the three-way cell maximum, and the registered result.
  gasm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .symbol_i       (symbol_i),
    .cmd_i          (cmd),
    .result_valid_o (result_valid_o),
    .score_o        (score_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .row_end_o      (row_end_o),
    .too_long_o     (too_long_o)
  );

endmodule

// ----- hdl/gasm_checker.sv -----
// ----------------------------------------------------------------------------
// gasm_checker
// Port-level checks on the result stream of the score matrix block.
// ----------------------------------------------------------------------------
module gasm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               result_valid_o,
  input logic signed [gasm_pkg::ScoreW-1:0] score_o,
  input logic [gasm_pkg::IdxW-1:0]          row_index_o,
  input logic [gasm_pkg::IdxW-1:0]          column_index_o,
  input logic                               row_end_o,
  input logic                               too_long_o
);

  // error results carry nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && too_long_o) |->
      (score_o == '0 && row_index_o == '0 && column_index_o == '0 && !row_end_o))
    else $error("error result carries cell data");

  // cells of a row follow on back to back with rising columns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !too_long_o && !row_end_o) |=>
      (result_valid_o && !too_long_o &&
       column_index_o == $past(column_index_o) + gasm_pkg::IdxW'(1) &&
       row_index_o == $past(row_index_o)))
    else $error("row walk broken");

  // a cell beyond column 0 always continues a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !too_long_o && column_index_o != '0) |->
      $past(result_valid_o))
    else $error("cell emitted without its predecessor");

  // the cycle after a row ends carries no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && row_end_o) |=> !result_valid_o)
    else $error("result straight after row end");

endmodule

bind global_alignment_score_matrix gasm_checker u_gasm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .score_o        (score_o),
  .row_index_o    (row_index_o),
  .column_index_o (column_index_o),
  .row_end_o      (row_end_o),
  .too_long_o     (too_long_o)
);
